// ===== hw/rtl/lad_pkg.sv =====
// Shared types, codes and helpers for the limit alarm / deadband monitor.
// Used by lad_csr, lad_eval and limit_alarm_with_deadband_monitor.
package lad_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int BAND_WIDTH     = VALUE_WIDTH - 1;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int REG_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;
   localparam int REQ_DATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int REQ_USER_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [REG_IDX_WIDTH-1:0] {
      REG_HIHI  = 3'd0,
      REG_HIGH  = 3'd1,
      REG_LOW   = 3'd2,
      REG_LOLO  = 3'd3,
      REG_SEVS  = 3'd4,
      REG_HYST  = 3'd5,
      REG_MDEL  = 3'd6,
      REG_ADEL  = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      STAT_NONE  = 3'd0,
      STAT_HIHI  = 3'd1,
      STAT_LOLO  = 3'd2,
      STAT_HIGH  = 3'd3,
      STAT_LOW   = 3'd4,
      STAT_UNDEF = 3'd5,
      STAT_LINK  = 3'd6
   } alarm_status_type;

   typedef enum logic [1:0] {
      SEV_NONE    = 2'd0,
      SEV_MINOR   = 2'd1,
      SEV_MAJOR   = 2'd2,
      SEV_INVALID = 2'd3
   } alarm_severity_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] limit_hihi;
      logic signed [VALUE_WIDTH-1:0] limit_high;
      logic signed [VALUE_WIDTH-1:0] limit_low;
      logic signed [VALUE_WIDTH-1:0] limit_lolo;
      logic [7:0]                    limit_severities;
      logic [BAND_WIDTH-1:0]         hysteresis;
      logic [BAND_WIDTH-1:0]         monitor_deadband;
      logic [BAND_WIDTH-1:0]         archive_deadband;
   } lad_cfg_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sample_value;
      logic                          value_obtained;
      logic                          link_fault;
   } lad_item_type;

   typedef struct packed {
      alarm_status_type   alarm_status;
      alarm_severity_type alarm_severity;
      logic               alarm_changed;
      logic               value_event;
      logic               archive_event;
   } lad_result_type;

   // Exact |a - b|; one extra bit keeps the subtraction from wrapping.
   function automatic logic [VALUE_WIDTH-1:0] abs_diff(
      input logic signed [VALUE_WIDTH-1:0] a,
      input logic signed [VALUE_WIDTH-1:0] b
   );
      logic signed [VALUE_WIDTH:0] diff;
      logic signed [VALUE_WIDTH:0] mag;
      diff = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      mag  = diff[VALUE_WIDTH] ? -diff : diff;
      return mag[VALUE_WIDTH-1:0];
   endfunction

endpackage

// ===== hw/rtl/limit_alarm_with_deadband_monitor.sv =====
// Top level of the limit alarm monitor with hysteresis and deadbands.
// Depends on lad_pkg, lad_csr and lad_eval.
//
// One sample transfer in gives one result transfer out. A sample is caught in
// an input register; from there it is checked against the hihi, lolo, high
// and low limits (hysteresis applied first, link fault and undefined value
// taking priority) and the monitor/archive deadbands, and when the stage
// advances the verdict lands in the output register, which drives rsp_tvalid,
// while the alarm and last-posted values update. The block sustains one
// sample per cycle while rsp_tready does not stall it: the only loop is the
// state update in the evaluation stage. Both stages advance together, so a
// stall on rsp_tready holds the input register and then drops req_tready.
// Limits, severities and bands are written through the csr_ port at byte
// address 4*index; write them only while no sample is in flight.
module limit_alarm_with_deadband_monitor import lad_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // sample stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [31:0] sample_value
   input  logic [REQ_USER_WIDTH-1:0] req_tuser,  // [0] value_obtained, [1] link_fault
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [2:0] alarm_status, [4:3] alarm_severity, [5] alarm_changed,
   // [6] value_event, [7] archive_event
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // configuration
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   lad_cfg_type    cfg;
   lad_item_type   item_ff, item_in;
   logic           in_valid_ff;
   lad_result_type result;
   lad_result_type out_ff;
   logic           out_valid_ff;
   logic           advance;   // evaluation stage hands its item to the output register
   logic           accept;

   lad_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lad_eval u_eval (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (item_ff),
      .result  (result)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   assign item_in.sample_value   = req_tdata[VALUE_WIDTH-1:0];
   assign item_in.value_obtained = req_tuser[0];
   assign item_in.link_fault     = req_tuser[1];

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.archive_event, out_ff.value_event, out_ff.alarm_changed,
                        out_ff.alarm_severity, out_ff.alarm_status};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

endmodule

// ===== hw/rtl/lad_csr.sv =====
// Configuration register file with APB-style access for the limit monitor.
// Depends on lad_pkg.
module lad_csr import lad_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output lad_cfg_type               cfg
);

   lad_cfg_type   cfg_ff;
   lad_cfg_type   cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_HIHI: cfg_in.limit_hihi       = csr_pwdata[VALUE_WIDTH-1:0];
            REG_HIGH: cfg_in.limit_high       = csr_pwdata[VALUE_WIDTH-1:0];
            REG_LOW:  cfg_in.limit_low        = csr_pwdata[VALUE_WIDTH-1:0];
            REG_LOLO: cfg_in.limit_lolo       = csr_pwdata[VALUE_WIDTH-1:0];
            REG_SEVS: cfg_in.limit_severities = csr_pwdata[7:0];
            REG_HYST: cfg_in.hysteresis       = csr_pwdata[BAND_WIDTH-1:0];
            REG_MDEL: cfg_in.monitor_deadband = csr_pwdata[BAND_WIDTH-1:0];
            REG_ADEL: cfg_in.archive_deadband = csr_pwdata[BAND_WIDTH-1:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_HIHI: csr_prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.limit_hihi));
         REG_HIGH: csr_prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.limit_high));
         REG_LOW:  csr_prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.limit_low));
         REG_LOLO: csr_prdata = CSR_DATA_WIDTH'(unsigned'(cfg_ff.limit_lolo));
         REG_SEVS: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.limit_severities);
         REG_HYST: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.hysteresis);
         REG_MDEL: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.monitor_deadband);
         REG_ADEL: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.archive_deadband);
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/lad_eval.sv =====
// Alarm evaluation: limit checks with hysteresis, deadband events, and the
// state they update. Depends on lad_pkg.
module lad_eval import lad_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  lad_cfg_type    cfg,
   input  logic           advance,
   input  lad_item_type   item,
   output lad_result_type result
);

   logic                          undefined_ff, undefined_in;
   logic signed [VALUE_WIDTH-1:0] last_alarm_ff, last_alarm_in;
   logic signed [VALUE_WIDTH-1:0] last_mon_ff, last_mon_in;
   logic signed [VALUE_WIDTH-1:0] last_arch_ff, last_arch_in;
   alarm_status_type              status_ff, status_in;
   alarm_severity_type            severity_ff, severity_in;

   logic signed [VALUE_WIDTH-1:0] raw;
   logic signed [VALUE_WIDTH-1:0] held;
   logic signed [VALUE_WIDTH-1:0] lim_hihi, lim_high, lim_low, lim_lolo;
   alarm_severity_type            sv_hihi, sv_high, sv_low, sv_lolo;
   logic                          vev, aev;

   assign raw      = item.sample_value;
   assign lim_hihi = cfg.limit_hihi;
   assign lim_high = cfg.limit_high;
   assign lim_low  = cfg.limit_low;
   assign lim_lolo = cfg.limit_lolo;
   assign sv_hihi  = alarm_severity_type'(cfg.limit_severities[1:0]);
   assign sv_high  = alarm_severity_type'(cfg.limit_severities[3:2]);
   assign sv_low   = alarm_severity_type'(cfg.limit_severities[5:4]);
   assign sv_lolo  = alarm_severity_type'(cfg.limit_severities[7:6]);

   // hold at the last alarm value while strictly inside the hysteresis band
   assign held = (abs_diff(last_alarm_ff, raw) < {1'b0, cfg.hysteresis}) ?
                 last_alarm_ff : raw;

   assign vev = abs_diff(last_mon_ff, raw)  > {1'b0, cfg.monitor_deadband};
   assign aev = abs_diff(last_arch_ff, raw) > {1'b0, cfg.archive_deadband};

   always_comb begin
      undefined_in  = undefined_ff & ~(~item.link_fault & item.value_obtained);
      last_alarm_in = last_alarm_ff;
      status_in     = STAT_NONE;
      severity_in   = SEV_NONE;
      if (item.link_fault) begin
         status_in   = STAT_LINK;
         severity_in = SEV_INVALID;
      end else if (undefined_in) begin
         status_in   = STAT_UNDEF;
         severity_in = SEV_INVALID;
      end else if (sv_hihi != SEV_NONE && held > lim_hihi) begin
         status_in     = STAT_HIHI;
         severity_in   = sv_hihi;
         last_alarm_in = held;
      end else if (sv_lolo != SEV_NONE && held < lim_lolo) begin
         status_in     = STAT_LOLO;
         severity_in   = sv_lolo;
         last_alarm_in = held;
      end else if (sv_high != SEV_NONE && held > lim_high) begin
         status_in     = STAT_HIGH;
         severity_in   = sv_high;
         last_alarm_in = held;
      end else if (sv_low != SEV_NONE && held < lim_low) begin
         status_in     = STAT_LOW;
         severity_in   = sv_low;
         last_alarm_in = held;
      end
      last_mon_in  = vev ? raw : last_mon_ff;
      last_arch_in = aev ? raw : last_arch_ff;
   end

   always_comb begin
      result.alarm_status   = status_in;
      result.alarm_severity = severity_in;
      result.alarm_changed  = (status_in != status_ff) || (severity_in != severity_ff);
      result.value_event    = vev;
      result.archive_event  = aev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         undefined_ff  <= 1'b1;
         last_alarm_ff <= '0;
         last_mon_ff   <= '0;
         last_arch_ff  <= '0;
         status_ff     <= STAT_NONE;
         severity_ff   <= SEV_NONE;
      end else if (advance) begin
         undefined_ff  <= undefined_in;
         last_alarm_ff <= last_alarm_in;
         last_mon_ff   <= last_mon_in;
         last_arch_ff  <= last_arch_in;
         status_ff     <= status_in;
         severity_ff   <= severity_in;
      end
   end

endmodule
